[design/simulation_calendar_clock_defines.svh]
// Assertion macros for the calendar clock top level.
`ifndef SIMULATION_CALENDAR_CLOCK_DEFINES_SVH
`define SIMULATION_CALENDAR_CLOCK_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define SCC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("calendar clock invariant violated");

// Same-cycle implication.
`define SCC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("calendar clock implication violated");

// Next-cycle implication.
`define SCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("calendar clock next-cycle check violated");

`endif

[design/scc_pkg.sv]
// Types, constants and month table for the calendar clock.
package scc_pkg;

	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [11:0] MAX_ADVANCE   = 12'd3600;
	localparam logic [4:0]  LAST_HOUR     = 5'd23;
	localparam logic [3:0]  LAST_MONTH    = 4'd12;

	localparam logic CMD_ADVANCE = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam logic [2:0] REG_START_YEAR  = 3'd0;
	localparam logic [2:0] REG_START_MONTH = 3'd1;
	localparam logic [2:0] REG_START_DAY   = 3'd2;
	localparam logic [2:0] REG_START_HOUR  = 3'd3;
	localparam logic [2:0] REG_END_YEAR    = 3'd4;
	localparam logic [2:0] REG_END_MONTH   = 3'd5;
	localparam logic [2:0] REG_END_DAY     = 3'd6;
	localparam logic [2:0] REG_END_HOUR    = 3'd7;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [16:0] sec;
	} clk_state_t;

	typedef struct packed {
		logic [15:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [4:0]  start_hour;
		logic [15:0] end_year;
		logic [3:0]  end_month;
		logic [4:0]  end_day;
		logic [4:0]  end_hour;
	} cfg_t;

	typedef struct packed {
		logic season_end;
		logic run_end;
		logic status;
	} flags_t;

	// Month length, no leap years; 0 for codes that are not a month.
	function automatic logic [4:0] days_in(input logic [3:0] m);
		logic [4:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2: d = 5'd28;
			default: d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

[design/scc_step.sv]
// Next-state and result logic for one command of the calendar clock.
module scc_step (
	input  scc_pkg::clk_state_t cur,
	input  scc_pkg::cfg_t       cfg,
	input  logic                cmd,
	input  logic [11:0]         seconds_to_add,
	output scc_pkg::clk_state_t nxt,
	output scc_pkg::flags_t     flags
);

	logic        cfg_ok;
	logic [11:0] secs;
	logic [16:0] sum;
	logic [17:0] thr;
	logic [4:0]  hour_inc;
	logic        status;

	always_comb begin
		cfg_ok = 1'b1;
		if (cfg.start_year > cfg.end_year)
			cfg_ok = 1'b0;
		if (cfg.start_month == 4'd0 || cfg.start_month > scc_pkg::LAST_MONTH ||
			cfg.end_month == 4'd0 || cfg.end_month > scc_pkg::LAST_MONTH)
			cfg_ok = 1'b0;
		if (cfg.start_day > scc_pkg::days_in(cfg.start_month) ||
			cfg.end_day > scc_pkg::days_in(cfg.end_month))
			cfg_ok = 1'b0;
		if (cfg.start_hour > scc_pkg::LAST_HOUR || cfg.end_hour > scc_pkg::LAST_HOUR)
			cfg_ok = 1'b0;
	end

	assign secs     = (seconds_to_add > scc_pkg::MAX_ADVANCE) ? scc_pkg::MAX_ADVANCE
		: seconds_to_add;
	assign sum      = 17'(cur.sec + 17'(secs));
	// sec / 3600 > hour  <=>  sec >= (hour + 1) * 3600
	assign thr      = 18'({1'b0, cur.hour} + 6'd1) * 18'(scc_pkg::SECS_PER_HOUR);
	assign hour_inc = 5'(cur.hour + 5'd1);

	always_comb begin
		nxt    = cur;
		status = 1'b0;
		if (cmd == scc_pkg::CMD_RESTART) begin
			if (cfg_ok) begin
				nxt.year  = cfg.start_year;
				nxt.month = cfg.start_month;
				nxt.day   = cfg.start_day;
				nxt.hour  = cfg.start_hour;
				nxt.sec   = 17'(17'(cfg.start_hour) * scc_pkg::SECS_PER_HOUR);
			end else begin
				status = 1'b1;
			end
		end else begin
			nxt.sec = sum;
			if ({1'b0, sum} >= thr) begin
				nxt.hour = hour_inc;
				if (hour_inc > scc_pkg::LAST_HOUR) begin
					nxt.sec  = 17'(sum - scc_pkg::SECS_PER_DAY);
					nxt.hour = 5'd0;
					if (scc_pkg::days_in(cur.month) == cur.day) begin
						nxt.day   = 5'd1;
						nxt.month = 4'(cur.month + 4'd1);
						if (4'(cur.month + 4'd1) > scc_pkg::LAST_MONTH) begin
							nxt.year  = 16'(cur.year + 16'd1);
							nxt.month = 4'd1;
						end
					end else begin
						nxt.day = 5'(cur.day + 5'd1);
					end
				end
			end
		end
	end

	always_comb begin
		flags.season_end = (nxt.month >= cfg.end_month) && (nxt.day >= cfg.end_day) &&
			(nxt.hour >= cfg.end_hour);
		flags.run_end    = nxt.year > cfg.end_year;
		flags.status     = status;
	end

endmodule

[design/simulation_calendar_clock.sv]
// Top level of the calendar clock (no leap years) with input and result registers.
//
// Usage:
//   Configuration: write cfg_data to register cfg_index with cfg_we high; registers are
//   start year/month/day/hour (0..3) and end year/month/day/hour (4..7). Write only
//   while no item is in flight. Start registers take effect at the next restart;
//   end registers apply to the two end flags from the next item on.
//   Input channel (in_valid/in_stall): cmd 0 advances by seconds_to_add (clamped to
//   3600), cmd 1 restarts from the start registers if the configuration is valid.
//   Result channel (out_valid/out_stall): one result per item with the date, hour,
//   second of day, the two end flags and status (1 = restart refused).
//   Path: an accepted item waits in the input register, then the step logic writes its
//   result to the result register. Throughput: one item per cycle while the result is
//   not stalled; the clock state register feeds the step logic and loads its next state.
//   Reset: configuration returns to 2000-01-01 00h start, 2000-12-31 23h end, and the
//   clock holds the start time with second of day 0; both channels are empty.
//   Stall: a stalled result holds; one more item waits in the input register, after
//   which in_stall rises.
`include "simulation_calendar_clock_defines.svh"

module simulation_calendar_clock (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [11:0] seconds_to_add,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] year_now,
	output logic [3:0]  month_now,
	output logic [4:0]  day_now,
	output logic [4:0]  hour_now,
	output logic [16:0] second_of_day,
	output logic        season_end_reached,
	output logic        run_end_reached,
	output logic        status
);

	scc_pkg::cfg_t       cfg_q;
	scc_pkg::clk_state_t state_q;
	scc_pkg::clk_state_t state_nxt;
	scc_pkg::flags_t     flags_nxt;
	scc_pkg::clk_state_t res_q;
	scc_pkg::flags_t     res_flags_q;

	logic        s1_valid_q;
	logic        cmd_s1;
	logic [11:0] secs_s1;
	logic        out_valid_q;
	logic        accept;
	logic        move;

	assign move     = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !(!out_valid_q || !out_stall);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_year  <= 16'd2000;
			cfg_q.start_month <= 4'd1;
			cfg_q.start_day   <= 5'd1;
			cfg_q.start_hour  <= 5'd0;
			cfg_q.end_year    <= 16'd2000;
			cfg_q.end_month   <= 4'd12;
			cfg_q.end_day     <= 5'd31;
			cfg_q.end_hour    <= 5'd23;
		end else if (cfg_we) begin
			case (cfg_index)
				scc_pkg::REG_START_YEAR:  cfg_q.start_year  <= cfg_data;
				scc_pkg::REG_START_MONTH: cfg_q.start_month <= cfg_data[3:0];
				scc_pkg::REG_START_DAY:   cfg_q.start_day   <= cfg_data[4:0];
				scc_pkg::REG_START_HOUR:  cfg_q.start_hour  <= cfg_data[4:0];
				scc_pkg::REG_END_YEAR:    cfg_q.end_year    <= cfg_data;
				scc_pkg::REG_END_MONTH:   cfg_q.end_month   <= cfg_data[3:0];
				scc_pkg::REG_END_DAY:     cfg_q.end_day     <= cfg_data[4:0];
				scc_pkg::REG_END_HOUR:    cfg_q.end_hour    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{year: 16'd2000, month: 4'd1, day: 5'd1, hour: 5'd0, sec: 17'd0};
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !move);
			if (move) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			secs_s1 <= seconds_to_add;
		end
		if (move) begin
			res_q       <= state_nxt;
			res_flags_q <= flags_nxt;
		end
	end

	scc_step u_step (
		.cur            (state_q),
		.cfg            (cfg_q),
		.cmd            (cmd_s1),
		.seconds_to_add (secs_s1),
		.nxt            (state_nxt),
		.flags          (flags_nxt)
	);

	assign out_valid          = out_valid_q;
	assign year_now           = res_q.year;
	assign month_now          = res_q.month;
	assign day_now            = res_q.day;
	assign hour_now           = res_q.hour;
	assign second_of_day      = res_q.sec;
	assign season_end_reached = res_flags_q.season_end;
	assign run_end_reached    = res_flags_q.run_end;
	assign status             = res_flags_q.status;

	`SCC_ASSERT_ALWAYS(a_hour_range, state_q.hour <= scc_pkg::LAST_HOUR)
	`SCC_ASSERT_ALWAYS(a_month_range,
		state_q.month != 4'd0 && state_q.month <= scc_pkg::LAST_MONTH)
	`SCC_ASSERT_ALWAYS(a_sec_in_hour,
		state_q.sec >= 17'(17'(state_q.hour) * scc_pkg::SECS_PER_HOUR))
	`SCC_ASSERT_NEXT(a_move_gives_result, move, out_valid_q)
	`SCC_ASSERT_NEXT(a_advance_ok, move && cmd_s1 == scc_pkg::CMD_ADVANCE, !res_flags_q.status)

endmodule
